/* sv/pfx_pkg.sv */
`default_nettype none
package pfx_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int LVL_W       = $clog2(STACK_DEPTH + 1);

	localparam int DATA_W      = 32;
	localparam int OP_W        = 3;
	localparam int ST_W        = 3;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 40;

	localparam int DIV_STEPS   = 32;
	localparam int CNT_W       = $clog2(DIV_STEPS);

	localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
	localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
	localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd1;
	localparam logic [ST_W-1:0] ST_DIVZERO   = 3'd2;
	localparam logic [ST_W-1:0] ST_UNKNOWN   = 3'd3;
	localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic            load;
		logic            push;
		logic            set_err;
		logic [ST_W-1:0] err_code;
		logic            rd_second;
		logic            alu_wr;
		logic            mul_start;
		logic            mul_wr;
		logic            div_start;
		logic            div_wr;
		logic            emit;
	} pfx_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            last;
		logic            err_set;
		logic            level_zero;
		logic            level_lt2;
		logic            full;
		logic            top_zero;
		logic            div_done;
		logic            out_free;
	} pfx_stat_t;

endpackage
`default_nettype wire

/* sv/postfix_expression_evaluator.sv */
// Postfix (RPN) evaluator over signed Q16.16 numbers, one token word at a time.
// Slave side s_*: one token per word; s_tdata holds operation and operand,
// s_tlast marks the token that ends the expression.
// Master side m_*: one result word per expression, carrying the top value and
// a status (ok, underflow, divide by zero, unknown operator, overflow).
// The value is zero whenever the status is not ok. First error is kept; the
// rest of that expression is ignored. Entries left under the top are dropped.
// Steps per token: a push or error is loaded and executed; add/sub read the
// second entry, then write the result; multiply registers the product first;
// divide waits on the restoring divider, which produces one quotient bit a
// cycle. An ending token then loads the result register once it is free.
// The result register parts the two sides: new tokens are taken while a
// result waits; only a second ending token holds (s_tready low) until the
// waiting result is taken. A stalled receiver therefore loses nothing.
// Reset (arst_n low) empties the stack, clears the error and drops any
// result not yet taken. The stack RAM itself is not cleared.
`default_nettype none
module postfix_expression_evaluator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// [2:0] operation, [34:3] operand_value, [39:35] zero
	input  wire logic [pfx_pkg::S_TDATA_W-1:0]  s_tdata,
	input  wire logic                           s_tlast,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [31:0] result_value, [34:32] status, [39:35] zero
	output logic [pfx_pkg::M_TDATA_W-1:0]       m_tdata
);

	// command and status between sequencer and datapath
	pfx_pkg::pfx_cmd_t  cmd;
	pfx_pkg::pfx_stat_t stat;

	pfx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pfx_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

/* sv/pfx_div.sv */
`default_nettype none
// Restoring divider, one quotient bit a cycle.
// Computes round(|a| * 2^16 / |b|), ties away from zero; ovf when quotient >= 2^32.
module pfx_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [pfx_pkg::DATA_W-1:0]    num_mag,
	input  wire logic [pfx_pkg::DATA_W-1:0]    den_mag,
	output logic                               done,
	output logic                               ovf,
	output logic [pfx_pkg::DATA_W:0]           q_mag
);

	logic                           busy_q;
	logic                           done_q;
	logic [pfx_pkg::CNT_W-1:0]      cnt_q;
	logic [pfx_pkg::DATA_W-1:0]     rem_q;
	logic [pfx_pkg::DATA_W-1:0]     quo_q;
	logic [pfx_pkg::DATA_W-1:0]     den_q;
	logic                           ovf_q;

	logic [pfx_pkg::DATA_W:0]       trial;
	logic                           take;
	logic [pfx_pkg::DATA_W:0]       trial_sub;
	logic                           round_up;

	always_comb begin
		trial     = {rem_q, quo_q[pfx_pkg::DATA_W-1]};
		take      = trial >= {1'b0, den_q};
		trial_sub = trial - {1'b0, den_q};
		round_up  = {rem_q, 1'b0} >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pfx_pkg::CNT_W'(pfx_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator is {|a|, 16'b0}; its top 16 bits seed the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {16'b0, num_mag[31:16]};
			quo_q <= {num_mag[15:0], 16'b0};
			den_q <= den_mag;
			ovf_q <= {16'b0, num_mag} >= {den_mag, 16'b0};
		end else if (busy_q) begin
			rem_q <= take ? trial_sub[pfx_pkg::DATA_W-1:0] : trial[pfx_pkg::DATA_W-1:0];
			quo_q <= {quo_q[pfx_pkg::DATA_W-2:0], take};
		end
	end

	assign done  = done_q;
	assign ovf   = ovf_q;
	assign q_mag = {1'b0, quo_q} + {{pfx_pkg::DATA_W{1'b0}}, round_up};

endmodule
`default_nettype wire

/* sv/pfx_dp.sv */
`default_nettype none
// Stack, arithmetic units and result register.
// Top of stack lives in top_q; entries below it sit in the stack RAM.
module pfx_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire pfx_pkg::pfx_cmd_t               cmd,
	output pfx_pkg::pfx_stat_t                   stat,
	input  wire logic [pfx_pkg::S_TDATA_W-1:0]   s_tdata,
	input  wire logic                            s_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [pfx_pkg::M_TDATA_W-1:0]        m_tdata
);

	logic [pfx_pkg::OP_W-1:0]   op_q;
	logic [pfx_pkg::DATA_W-1:0] val_q;
	logic                       last_q;

	logic [pfx_pkg::LVL_W-1:0]  level_q;
	logic [pfx_pkg::ST_W-1:0]   err_q;
	logic [pfx_pkg::DATA_W-1:0] top_q;
	logic [pfx_pkg::DATA_W-1:0] rd_q;
	logic [pfx_pkg::DATA_W-1:0] mem [pfx_pkg::STACK_DEPTH];

	logic [63:0]                prod_s1;

	logic                       out_valid_q;
	logic [pfx_pkg::DATA_W-1:0] res_q;
	logic [pfx_pkg::ST_W-1:0]   st_q;

	logic [pfx_pkg::LVL_W-1:0]  lvl_m1;
	logic [pfx_pkg::LVL_W-1:0]  lvl_m2;
	logic                       level_zero;
	logic                       neg;
	logic [pfx_pkg::DATA_W-1:0] mag_a;
	logic [pfx_pkg::DATA_W-1:0] mag_b;
	logic [pfx_pkg::DATA_W:0]   sum;
	logic [pfx_pkg::DATA_W-1:0] alu_res;
	logic [63:0]                prod;
	logic [63:0]                prod_rnd;
	logic [pfx_pkg::DATA_W-1:0] mul_res;
	logic [pfx_pkg::DATA_W-1:0] div_res;
	logic                       div_done;
	logic                       div_ovf;
	logic [pfx_pkg::DATA_W:0]   div_q;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		mag32 = v[31] ? (32'd0 - v) : v;
	endfunction

	function automatic logic [31:0] from_mag(input logic [47:0] m, input logic n);
		if (n) begin
			from_mag = (m >= 48'h0000_8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
		end else begin
			from_mag = (m > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
		end
	endfunction

	always_comb begin
		lvl_m1     = level_q - pfx_pkg::LVL_W'(1);
		lvl_m2     = level_q - pfx_pkg::LVL_W'(2);
		level_zero = (level_q == '0);
		neg        = rd_q[31] ^ top_q[31];
		mag_a      = mag32(rd_q);
		mag_b      = mag32(top_q);

		// add / subtract with saturation
		if (op_q == pfx_pkg::OP_SUB) begin
			sum = {rd_q[31], rd_q} - {top_q[31], top_q};
		end else begin
			sum = {rd_q[31], rd_q} + {top_q[31], top_q};
		end
		if (sum[32] != sum[31]) begin
			alu_res = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			alu_res = sum[31:0];
		end

		prod     = {32'd0, mag_a} * {32'd0, mag_b};
		prod_rnd = prod_s1 + 64'h0000_0000_0000_8000;
		mul_res  = from_mag(prod_rnd[63:16], neg);

		if (div_ovf) begin
			div_res = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			div_res = from_mag({15'd0, div_q}, neg);
		end
	end

	pfx_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.num_mag (mag_a),
		.den_mag (mag_b),
		.done    (div_done),
		.ovf     (div_ovf),
		.q_mag   (div_q)
	);

	// token word, top of stack and product registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= s_tdata[2:0];
			val_q  <= s_tdata[34:3];
			last_q <= s_tlast;
		end
		if (cmd.push) begin
			top_q <= val_q;
		end else if (cmd.alu_wr) begin
			top_q <= alu_res;
		end else if (cmd.mul_wr) begin
			top_q <= mul_res;
		end else if (cmd.div_wr) begin
			top_q <= div_res;
		end
		if (cmd.mul_start) begin
			prod_s1 <= prod;
		end
	end

	// stack RAM: old top goes down on a push, second is read for an operator
	always_ff @(posedge clk) begin
		if (cmd.push && !level_zero) begin
			mem[lvl_m1[pfx_pkg::IDX_W-1:0]] <= top_q;
		end
		if (cmd.rd_second) begin
			rd_q <= mem[lvl_m2[pfx_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			err_q   <= pfx_pkg::ST_OK;
		end else begin
			if (cmd.emit) begin
				level_q <= '0;
				err_q   <= pfx_pkg::ST_OK;
			end else begin
				if (cmd.push) begin
					level_q <= level_q + pfx_pkg::LVL_W'(1);
				end else if (cmd.alu_wr || cmd.mul_wr || cmd.div_wr) begin
					level_q <= lvl_m1;
				end
				if (cmd.set_err) begin
					err_q <= cmd.err_code;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (err_q != pfx_pkg::ST_OK) begin
				res_q <= '0;
				st_q  <= err_q;
			end else if (level_zero) begin
				res_q <= '0;
				st_q  <= pfx_pkg::ST_UNDERFLOW;
			end else begin
				res_q <= top_q;
				st_q  <= pfx_pkg::ST_OK;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, st_q, res_q};

	always_comb begin
		stat.op         = op_q;
		stat.last       = last_q;
		stat.err_set    = (err_q != pfx_pkg::ST_OK);
		stat.level_zero = level_zero;
		stat.level_lt2  = (level_q < pfx_pkg::LVL_W'(2));
		stat.full       = (level_q >= pfx_pkg::LVL_W'(pfx_pkg::STACK_DEPTH));
		stat.top_zero   = (top_q == '0);
		stat.div_done   = div_done;
		stat.out_free   = !out_valid_q || m_tready;
	end

endmodule
`default_nettype wire

/* sv/pfx_ctrl.sv */
`default_nettype none
// Token sequencer.
module pfx_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire pfx_pkg::pfx_stat_t  stat,
	output pfx_pkg::pfx_cmd_t        cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_OPER,
		S_MUL,
		S_DIV,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t after_tok;

	always_comb begin
		after_tok = stat.last ? S_EMIT : S_IDLE;
		state_d   = state_q;
		cmd       = '0;
		s_tready  = (state_q == S_IDLE);

		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = after_tok;
				if (!stat.err_set) begin
					case (stat.op)
						pfx_pkg::OP_PUSH: begin
							if (stat.full) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = pfx_pkg::ST_OVERFLOW;
							end else begin
								cmd.push = 1'b1;
							end
						end
						pfx_pkg::OP_ADD, pfx_pkg::OP_SUB,
						pfx_pkg::OP_MUL, pfx_pkg::OP_DIV: begin
							// divide by zero wins over underflow
							if (stat.op == pfx_pkg::OP_DIV && !stat.level_zero &&
									stat.top_zero) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = pfx_pkg::ST_DIVZERO;
							end else if (stat.level_lt2) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = pfx_pkg::ST_UNDERFLOW;
							end else begin
								cmd.rd_second = 1'b1;
								state_d       = S_OPER;
							end
						end
						default: begin
							cmd.set_err  = 1'b1;
							cmd.err_code = pfx_pkg::ST_UNKNOWN;
						end
					endcase
				end
			end
			S_OPER: begin
				case (stat.op)
					pfx_pkg::OP_ADD, pfx_pkg::OP_SUB: begin
						cmd.alu_wr = 1'b1;
						state_d    = after_tok;
					end
					pfx_pkg::OP_MUL: begin
						cmd.mul_start = 1'b1;
						state_d       = S_MUL;
					end
					pfx_pkg::OP_DIV: begin
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end
					default: begin
						state_d = after_tok;
					end
				endcase
			end
			S_MUL: begin
				cmd.mul_wr = 1'b1;
				state_d    = after_tok;
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.div_wr = 1'b1;
					state_d    = after_tok;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* tb/pfx_result_checker.sv */
`default_nettype none
// Watches both stream sides, keeps its own copy of the evaluator state and
// compares each result word against the oldest prediction.
module pfx_result_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	input  wire logic [pfx_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic                          s_tlast,
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [pfx_pkg::M_TDATA_W-1:0] m_tdata,
	output int                                 mismatch_count,
	output int                                 results_pending
);
	import pfx_pkg::*;

	typedef struct packed {
		logic [ST_W-1:0]          status;
		logic signed [DATA_W-1:0] value;
	} rpn_result_t;

	localparam longint unsigned POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
	localparam longint unsigned NEG_LIMIT = 64'h0000_0000_8000_0000;

	logic signed [DATA_W-1:0] operand_mem [STACK_DEPTH];
	int                       stack_fill;
	logic [ST_W-1:0]          first_error;
	rpn_result_t              expected_results [$];
	rpn_result_t              got, want;
	int                       result_index;

	function automatic logic signed [DATA_W-1:0] clamp_sum(input longint v);
		if (v > longint'(POS_LIMIT))
			return 32'sh7FFF_FFFF;
		if (v < -longint'(NEG_LIMIT))
			return 32'sh8000_0000;
		return v[DATA_W-1:0];
	endfunction

	function automatic longint unsigned magnitude(input logic signed [DATA_W-1:0] v);
		longint w;
		w = v;
		return (w < 0) ? longint'(-w) : longint'(w);
	endfunction

	function automatic logic signed [DATA_W-1:0] apply_sign(input longint unsigned m,
			input logic neg);
		longint w;
		if (neg) begin
			if (m >= NEG_LIMIT)
				return 32'sh8000_0000;
			w = -longint'(m);
			return w[DATA_W-1:0];
		end
		if (m > POS_LIMIT)
			return 32'sh7FFF_FFFF;
		return m[DATA_W-1:0];
	endfunction

	// Q16.16 product, round half away from zero on the magnitude
	function automatic logic signed [DATA_W-1:0] fixed_mul(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		longint unsigned m;
		m = magnitude(a) * magnitude(b);
		m = (m + 64'h8000) >> 16;
		return apply_sign(m, (a < 0) != (b < 0));
	endfunction

	function automatic logic signed [DATA_W-1:0] fixed_div(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		longint unsigned num, den, q;
		num = magnitude(a) << 16;
		den = magnitude(b);
		q   = (2 * num + den) / (2 * den);
		return apply_sign(q, (a < 0) != (b < 0));
	endfunction

	task automatic eval_token(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val,
			input logic last);
		logic signed [DATA_W-1:0] top, second, res;
		rpn_result_t              r;
		if (first_error == ST_OK) begin
			if (op == OP_PUSH) begin
				if (stack_fill >= STACK_DEPTH)
					first_error = ST_OVERFLOW;
				else begin
					operand_mem[stack_fill] = val;
					stack_fill++;
				end
			end else if (op > OP_DIV)
				first_error = ST_UNKNOWN;
			else if (op == OP_DIV && stack_fill >= 1 && operand_mem[stack_fill-1] == 0)
				// zero divisor wins over underflow, even with one entry
				first_error = ST_DIVZERO;
			else if (stack_fill < 2)
				first_error = ST_UNDERFLOW;
			else begin
				top    = operand_mem[stack_fill-1];
				second = operand_mem[stack_fill-2];
				case (op)
					OP_ADD: res = clamp_sum(longint'(second) + longint'(top));
					OP_SUB: res = clamp_sum(longint'(second) - longint'(top));
					OP_MUL: res = fixed_mul(second, top);
					default: res = fixed_div(second, top);
				endcase
				stack_fill--;
				operand_mem[stack_fill-1] = res;
			end
		end
		if (last) begin
			r.status = first_error;
			r.value  = '0;
			if (first_error == ST_OK) begin
				if (stack_fill == 0)
					r.status = ST_UNDERFLOW;
				else
					r.value = operand_mem[stack_fill-1];
			end
			expected_results.push_back(r);
			stack_fill  = 0;
			first_error = ST_OK;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_fill      = 0;
			first_error     = ST_OK;
			expected_results.delete();
			mismatch_count  = 0;
			results_pending = 0;
			result_index    = 0;
		end else begin
			// result side first: a word leaving now never stems from a token taken now
			if (m_tvalid && m_tready) begin
				got.value  = m_tdata[DATA_W-1:0];
				got.status = m_tdata[DATA_W +: ST_W];
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result %0d: unexpected word, value %h status %0d",
							result_index, got.value, got.status);
				end else begin
					want = expected_results.pop_front();
					if (got.value !== want.value || got.status !== want.status) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("result %0d: expected value %h status %0d, got value %h status %0d",
								result_index, want.value, want.status, got.value, got.status);
					end
				end
				result_index++;
			end
			if (s_tvalid && s_tready)
				eval_token(s_tdata[OP_W-1:0], s_tdata[OP_W +: DATA_W], s_tlast);
			results_pending = expected_results.size();
		end
	end

endmodule
`default_nettype wire

/* tb/tb_postfix_expression_evaluator.sv */
`default_nettype none
// Top: clock, reset, token stimulus, result-side back-pressure and verdict.
// All prediction and comparison lives in pfx_result_checker.
module tb_postfix_expression_evaluator;
	import pfx_pkg::*;

	localparam int RANDOM_TOKENS = 800;
	localparam int LIMIT         = 400000; // cycles, far above the slowest legal run
	localparam int DRAIN_CYCLES  = 60;
	localparam int LONG_HOLD     = 400;    // receiver hold-off while tokens keep coming
	localparam int UNKNOWN_TOP   = (1 << OP_W) - 1;

	localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;

	int mismatch_count;
	int results_pending;

	// knobs read by the driving processes, written by the stimulus only
	int idle_pct;
	int stall_pct;
	int token_count;
	logic long_hold_req;

	int cycle_count;

	postfix_expression_evaluator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	pfx_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Operand mix: zeros (divide-by-zero), the rails (saturation), small
	// integers (exact sums), the one-LSB values and plenty of raw noise.
	function automatic logic signed [DATA_W-1:0] random_operand();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = Q_MAX;
			2: v = Q_MIN;
			3: begin
				v = $urandom_range(0, 20) << 16;
				if ($urandom_range(0, 1))
					v = -v;
			end
			4: v = $urandom_range(0, 1) ? 32'sh0000_0001 : 32'shFFFF_FFFF;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// One token word. Caller sits just after a rising edge; inputs move on the
	// falling edge, one assignment per signal per edge.
	task automatic offer_token(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value,
			input logic last);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - OP_W - DATA_W){1'b0}}, value, op};
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		token_count++;
	endtask

	// Mostly well-formed expressions with random content so that deep stacks
	// and real arithmetic are reached; the rest overflows or is raw noise.
	task automatic issue_expression();
		int pick, len, depth, push_bias, i;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			len       = $urandom_range(1, 24);
			push_bias = $urandom_range(1, 3);
			depth     = 0;
			for (i = 0; i < len; i++) begin
				if (depth < 2 || (depth < STACK_DEPTH && $urandom_range(0, 3) < push_bias)) begin
					offer_token(OP_PUSH, random_operand(), i == len - 1);
					depth++;
				end else begin
					offer_token(OP_W'(OP_ADD + $urandom_range(0, 3)), random_operand(),
						i == len - 1);
					depth--;
				end
			end
		end else if (pick < 80) begin
			// fill the stack and sometimes run past its top, then try to fold
			len = STACK_DEPTH + $urandom_range(0, 3);
			for (i = 0; i < len; i++)
				offer_token(OP_PUSH, random_operand(), 1'b0);
			offer_token(OP_W'(OP_ADD + $urandom_range(0, 3)), random_operand(), 1'b1);
		end else begin
			len = $urandom_range(1, 8);
			for (i = 0; i < len; i++)
				offer_token(OP_W'($urandom_range(0, UNKNOWN_TOP)), random_operand(),
					i == len - 1 || $urandom_range(0, 7) == 0);
		end
	endtask

	// Result side: random stalls, plus one long hold-off so that a second
	// ending token backs the block up into s_tready.
	initial begin : result_sink
		int   long_hold_left;
		logic long_hold_done;
		long_hold_left = 0;
		long_hold_done = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req && !long_hold_done) begin
				long_hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (long_hold_left > 0) begin
				m_tready <= 1'b0;
				long_hold_left--;
			end else
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int random_start;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		arst_n        = 1'b0;
		idle_pct      = 0;
		stall_pct     = 30;
		token_count   = 0;
		long_hold_req = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// operator on an empty stack
		offer_token(OP_ADD, '0, 1'b1);
		// saturating add at the top rail
		offer_token(OP_PUSH, Q_MAX, 1'b0);
		offer_token(OP_PUSH, Q_MAX, 1'b0);
		offer_token(OP_ADD, '0, 1'b1);
		// saturating subtract at the bottom rail
		offer_token(OP_PUSH, Q_MIN, 1'b0);
		offer_token(OP_PUSH, 32'sh0000_0001, 1'b0);
		offer_token(OP_SUB, '0, 1'b1);
		// product of two most-negative values clips high
		offer_token(OP_PUSH, Q_MIN, 1'b0);
		offer_token(OP_PUSH, Q_MIN, 1'b0);
		offer_token(OP_MUL, '0, 1'b1);
		// 1.5 / -2 = -0.75
		offer_token(OP_PUSH, 32'sh0001_8000, 1'b0);
		offer_token(OP_PUSH, -(2 * Q_ONE), 1'b0);
		offer_token(OP_DIV, '0, 1'b1);
		// zero divisor with two entries, then with only one
		offer_token(OP_PUSH, 5 * Q_ONE, 1'b0);
		offer_token(OP_PUSH, '0, 1'b0);
		offer_token(OP_DIV, '0, 1'b1);
		offer_token(OP_PUSH, '0, 1'b0);
		offer_token(OP_DIV, '0, 1'b1);
		// unknown operator code
		offer_token(OP_W'(UNKNOWN_TOP), 32'shFFFF_FFFF, 1'b1);
		// leftover entry under the top is dropped
		offer_token(OP_PUSH, 3 * Q_ONE, 1'b0);
		offer_token(OP_PUSH, 32'shFFFF_FFFF, 1'b1);
		// error stays put while later tokens would succeed
		offer_token(OP_W'(OP_DIV + 1), Q_ONE, 1'b0);
		offer_token(OP_PUSH, Q_ONE, 1'b0);
		offer_token(OP_PUSH, 2 * Q_ONE, 1'b0);
		offer_token(OP_ADD, '0, 1'b1);

		// random part, four idling phases of roughly equal length
		random_start = token_count;
		while (token_count - random_start < RANDOM_TOKENS) begin
			if (token_count - random_start < RANDOM_TOKENS / 4) begin
				idle_pct  = 0;
				stall_pct = 0;
				if (token_count - random_start > 40)
					long_hold_req = 1'b1;
			end else if (token_count - random_start < RANDOM_TOKENS / 2) begin
				idle_pct  = 53;
				stall_pct = 0;
			end else if (token_count - random_start < 3 * RANDOM_TOKENS / 4) begin
				idle_pct  = 0;
				stall_pct = 53;
			end else begin
				idle_pct  = 27;
				stall_pct = 27;
			end
			issue_expression();
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		wait (results_pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
sv/pfx_pkg.sv
sv/pfx_div.sv
sv/pfx_dp.sv
sv/pfx_ctrl.sv
sv/postfix_expression_evaluator.sv
tb/pfx_result_checker.sv
tb/tb_postfix_expression_evaluator.sv
